>>> rtl/fifo_queue_with_value_purge_defines.svh
// Assertion macros shared by the queue's RTL files.
// Depends on nothing; included by the files that carry assertions.
`ifndef FIFO_QUEUE_WITH_VALUE_PURGE_DEFINES_SVH
`define FIFO_QUEUE_WITH_VALUE_PURGE_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define FQVP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off during reset.
`define FQVP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fqvp_pkg.sv
// Shared types and constants for the value-purging queue.
// No dependencies; imported by the sequencer and the top level.
package fqvp_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_PURGE = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic                        done;
    logic signed [WORD_BITS-1:0] word;
    logic [CNT_BITS-1:0]         count;
    logic [1:0]                  err;
  } res_t;

  // Ring store access for one cycle.
  typedef struct packed {
    logic                        we;
    logic [IDX_BITS-1:0]         waddr;
    logic signed [WORD_BITS-1:0] wdata;
    logic [IDX_BITS-1:0]         raddr;
  } ram_req_t;

endpackage

>>> rtl/fqvp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fqvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fqvp_seq.sv
// Queue sequencer: head and count registers, head cache and the purge walk.
// Depends on fqvp_pkg and the assertion macros; drives the ring store RAM.
`include "fifo_queue_with_value_purge_defines.svh"

module fqvp_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic signed [fqvp_pkg::WORD_BITS-1:0] value,
  input  logic                                  out_free,
  input  logic signed [fqvp_pkg::WORD_BITS-1:0] rd_data,
  output fqvp_pkg::ram_req_t                    ram_req,
  output fqvp_pkg::res_t                        res
);
  import fqvp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state, state_next;
  logic [IDX_BITS-1:0]         head_index, head_index_next;
  logic [CNT_BITS-1:0]         held_count, held_count_next;
  logic signed [WORD_BITS-1:0] head_word, head_word_next;
  logic signed [WORD_BITS-1:0] res_word, res_word_next;
  logic signed [WORD_BITS-1:0] victim, victim_next;
  logic [CNT_BITS-1:0]         rd_k, rd_k_next;
  logic [CNT_BITS-1:0]         cmp_k, cmp_k_next;
  logic [CNT_BITS-1:0]         kept, kept_next;
  logic                        in_fire;
  logic                        match;

  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  // The one compare unit, reused for every entry the purge walk reads.
  assign match    = (rd_data == victim);

  always_comb begin
    state_next      = state;
    head_index_next = head_index;
    held_count_next = held_count;
    head_word_next  = head_word;
    res_word_next   = res_word;
    victim_next     = victim;
    rd_k_next       = rd_k;
    cmp_k_next      = cmp_k;
    kept_next       = kept;
    ram_req.we      = 1'b0;
    ram_req.waddr   = head_index + held_count[IDX_BITS-1:0];
    ram_req.wdata   = value;
    ram_req.raddr   = head_index + IDX_BITS'(1);
    res.done        = 1'b0;
    res.word        = '0;
    res.err         = ERR_OK;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (operation)
            OP_PUSH: begin
              res.done = 1'b1;
              if (held_count == FULL_COUNT) begin
                res.err  = ERR_FULL;
                res.word = head_word;
              end else begin
                ram_req.we      = 1'b1;
                held_count_next = held_count + CNT_BITS'(1);
                if (held_count == '0) begin
                  head_word_next = value;
                  res.word       = value;
                end else begin
                  res.word = head_word;
                end
              end
            end
            OP_POP: begin
              if (held_count == '0) begin
                res.done = 1'b1;
                res.err  = ERR_EMPTY;
              end else if (held_count == CNT_BITS'(1)) begin
                res.done        = 1'b1;
                res.word        = head_word;
                held_count_next = '0;
                head_index_next = '0;
              end else begin
                // The new head has to come out of the RAM before the result.
                res_word_next   = head_word;
                held_count_next = held_count - CNT_BITS'(1);
                head_index_next = head_index + IDX_BITS'(1);
                state_next      = S_POP;
              end
            end
            OP_CLEAR: begin
              res.done        = 1'b1;
              held_count_next = '0;
              head_index_next = '0;
            end
            OP_PURGE: begin
              if (held_count == '0) begin
                res.done = 1'b1;
              end else begin
                victim_next   = value;
                ram_req.raddr = head_index;
                rd_k_next     = CNT_BITS'(1);
                cmp_k_next    = '0;
                kept_next     = '0;
                state_next    = S_WALK;
              end
            end
            default: begin
              res.done = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        head_word_next = rd_data;
        state_next     = S_FIN;
      end
      S_WALK: begin
        // Survivors are written back at the kept offset, which never passes
        // the read offset, so no entry is overwritten before it is read.
        if (!match) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = head_index + kept[IDX_BITS-1:0];
          ram_req.wdata = rd_data;
          kept_next     = kept + CNT_BITS'(1);
          if (kept == '0) begin
            head_word_next = rd_data;
          end
        end
        if (rd_k < held_count) begin
          ram_req.raddr = head_index + rd_k[IDX_BITS-1:0];
          rd_k_next     = rd_k + CNT_BITS'(1);
        end
        cmp_k_next = cmp_k + CNT_BITS'(1);
        if (cmp_k == held_count - CNT_BITS'(1)) begin
          held_count_next = kept_next;
          state_next      = S_FIN;
          if (kept_next == '0) begin
            head_index_next = '0;
            res_word_next   = '0;
          end else begin
            res_word_next = head_word_next;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          res.done   = 1'b1;
          res.word   = res_word;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.count = held_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_index <= '0;
      held_count <= '0;
      rd_k       <= '0;
      cmp_k      <= '0;
      kept       <= '0;
    end else begin
      state      <= state_next;
      head_index <= head_index_next;
      held_count <= held_count_next;
      rd_k       <= rd_k_next;
      cmp_k      <= cmp_k_next;
      kept       <= kept_next;
    end
  end

  always_ff @(posedge clk) begin
    head_word <= head_word_next;
    res_word  <= res_word_next;
    victim    <= victim_next;
  end

  `FQVP_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, held_count <= FULL_COUNT,
    "entry count exceeds the store depth")
  `FQVP_ASSERT_IMPL(a_empty_head, clk, rst, held_count == '0, head_index == '0,
    "empty queue with a non-zero head index")
  `FQVP_ASSERT_IMPL(a_walk_kept, clk, rst, state == S_WALK, kept <= cmp_k,
    "purge kept more entries than it has compared")
  `FQVP_ASSERT_NEXT(a_pop_dec, clk, rst,
    in_fire && (operation == OP_POP) && (held_count != '0),
    held_count == ($past(held_count) - CNT_BITS'(1)),
    "pop on a non-empty queue did not drop the count by one")

endmodule

>>> rtl/fifo_queue_with_value_purge.sv
// Bounded queue of signed words with push, pop, clear and purge-by-value.
// Depends on fqvp_pkg, fqvp_seq, fqvp_ram and the assertion macros.
// Push, clear, last-entry pop, empty purge, errors: one per cycle unless output stalls.
// Pop that leaves entries: S_POP reads the new head from the RAM, then S_FIN.
// Purge of a non-empty queue: S_WALK compares one entry per cycle, then S_FIN.
// Synchronous reset empties the queue; stored words are not cleared.
`include "fifo_queue_with_value_purge_defines.svh"

module fifo_queue_with_value_purge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic signed [fqvp_pkg::WORD_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fqvp_pkg::WORD_BITS-1:0] head_word,
  output logic [fqvp_pkg::CNT_BITS-1:0]         entry_count,
  output logic                                  is_empty,
  output logic [1:0]                            error_code
);
  import fqvp_pkg::*;

  ram_req_t                    ram_req;
  res_t                        res;
  logic signed [WORD_BITS-1:0] rd_data;
  logic                        out_free;

  assign out_free = !out_valid || out_ready;

  fqvp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_free  (out_free),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res       (res)
  );

  fqvp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // Output register: holds one finished request until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      head_word   <= res.word;
      entry_count <= res.count;
      is_empty    <= (res.count == '0);
      error_code  <= res.err;
    end
  end

  `FQVP_ASSERT_IMPL(a_no_overwrite, clk, rst, res.done, out_free,
    "result produced while the output register still holds one")
  `FQVP_ASSERT_IMPL(a_empty_flag, clk, rst, out_valid,
    is_empty == (entry_count == '0),
    "empty flag disagrees with the entry count")

endmodule
